// ===== hw/rtl/dconv_pkg.sv =====
package dconv_pkg;

   localparam int TAP_ROWS         = 3;
   localparam int TAP_COLS         = 3;
   localparam int MAX_IN_CHANNELS  = 16;
   localparam int MAX_OUT_CHANNELS = 16;
   localparam int MAX_HEIGHT       = 64;
   localparam int MAX_WIDTH        = 64;

   localparam int FEAT_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * TAP_ROWS * TAP_COLS;
   localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
   localparam int WGT_AW     = $clog2(WGT_DEPTH);
   localparam int TAPS_PER_OC = MAX_IN_CHANNELS * TAP_ROWS * TAP_COLS;
   localparam int ROW_AW     = $clog2(MAX_HEIGHT);
   localparam int COL_AW     = $clog2(MAX_WIDTH);
   localparam int CH_AW      = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
   localparam int KR_AW      = (TAP_ROWS > 1) ? $clog2(TAP_ROWS) : 1;
   localparam int KC_AW      = (TAP_COLS > 1) ? $clog2(TAP_COLS) : 1;

   // Signed tap coordinate: row*stride - pad + tap*dilation
   localparam int COORD_W = 13;
   localparam int ACC_W   = 40;
   localparam int CSR_DW  = 7;
   localparam int CSR_IW  = 3;

   typedef enum logic [1:0] {
      CMD_LOAD_ACT  = 2'd0,
      CMD_LOAD_WGT  = 2'd1,
      CMD_LOAD_BIAS = 2'd2,
      CMD_COMPUTE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_SATURATED = 2'd1,
      STS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [CSR_IW-1:0] {
      REG_IN_HEIGHT   = 3'd0,
      REG_IN_WIDTH    = 3'd1,
      REG_IN_CHANNELS = 3'd2,
      REG_STRIDE_ROWS = 3'd3,
      REG_STRIDE_COLS = 3'd4,
      REG_PAD_ROWS    = 3'd5,
      REG_PAD_COLS    = 3'd6,
      REG_DILATION    = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

// ===== hw/rtl/direct_conv2d_engine_top.sv =====
// Direct 2D convolution engine, fixed point.
// Input channel: start/busy command port. An item is taken at a clock edge with
// start high and busy low. Load activation, load weight and load bias items are
// written into their stores at that edge and give no result; busy stays low.
// A compute item names an output channel, row and column. Its result appears on
// rsp_result_value/rsp_status for one cycle with rsp_strobe high.
// Compute: the sequencer walks the taps, one multiply-accumulate per cycle, set by
// the single read port of the feature and weight memories; the memory reads, the
// product and the saturated result are registered in turn. Taps that land in the
// padding are still walked and add zero. A coordinate beyond the output size
// answers in the cycle after it is taken, with status out-of-range and value 0.
// One compute item is worked on at a time; busy is high until its result shows.
// Configuration: csr_wr_en/csr_index/csr_wr_data, taken at once; write only while idle (not enforced by the block).
// Reset: registers return to their defaults, the bias store clears to zero; the
// feature and weight memories are not cleared and read undefined until loaded.
// The receiver cannot stall: each result is taken in its strobe cycle.
module direct_conv2d_engine_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_command,
   input  logic [3:0]                             req_out_channel,
   input  logic [3:0]                             req_in_channel,
   input  logic [6:0]                             req_row,
   input  logic [6:0]                             req_col,
   input  logic [1:0]                             req_kernel_row,
   input  logic [1:0]                             req_kernel_col,
   input  logic signed [31:0]                     req_value,
   output logic                                   rsp_strobe,
   output logic signed [31:0]                     rsp_result_value,
   output logic [1:0]                             rsp_status,
   input  logic                                   csr_wr_en,
   input  logic [dconv_pkg::CSR_IW-1:0]           csr_index,
   input  logic [dconv_pkg::CSR_DW-1:0]           csr_wr_data
);
   import dconv_pkg::*;

   // Configuration registers
   logic [6:0] in_height_ff, in_width_ff;
   logic [4:0] in_channels_ff;
   logic [3:0] stride_rows_ff, stride_cols_ff, dilation_ff;
   logic [2:0] pad_rows_ff, pad_cols_ff;

   // Stores
   logic signed [15:0] feat_mem_ff [FEAT_DEPTH];
   logic signed [15:0] wgt_mem_ff  [WGT_DEPTH];
   logic signed [31:0] bias_ff     [MAX_OUT_CHANNELS];

   state_type state_ff, state_in;

   logic accept, do_compute, coord_ok, tap_last;

   // Effective register values
   logic [6:0] h_eff, w_eff;
   logic [4:0] c_eff;
   logic [3:0] sr_eff, sc_eff, d_eff;

   logic [10:0] row_mul, col_mul;
   logic signed [COORD_W-1:0] num_rows, num_cols, rbase, cbase;

   // Tap sequencer
   logic [CH_AW-1:0] c_ff, c_last;
   logic [KR_AW-1:0] a_ff;
   logic [KC_AW-1:0] b_ff;
   logic signed [COORD_W-1:0] ih_ff, iw_ff, rbase_ff, cbase_ff;
   logic [WGT_AW-1:0] waddr_ff;
   logic tap_ok;

   logic [FEAT_AW-1:0] feat_raddr, feat_waddr;
   logic [WGT_AW-1:0]  wgt_waddr;
   logic               feat_we, wgt_we;
   logic signed [15:0] load_sat;

   // Pipeline
   logic p1_valid_ff, p1_last_ff, p1_ok_ff;
   logic p2_valid_ff, p2_last_ff;
   logic signed [15:0] feat_rd_ff, wgt_rd_ff;
   logic signed [31:0] product_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_sum;

   logic                rsp_strobe_ff;
   logic signed [31:0]  rsp_value_ff;
   status_type          rsp_status_ff;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      if (v > 32'sd32767) begin
         sat16 = 16'sh7FFF;
      end else if (v < -32'sd32768) begin
         sat16 = -16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

   always_comb begin
      h_eff  = (in_height_ff == 7'd0) ? 7'd1 :
               (32'(in_height_ff) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : in_height_ff;
      w_eff  = (in_width_ff == 7'd0) ? 7'd1 :
               (32'(in_width_ff) > MAX_WIDTH) ? 7'(MAX_WIDTH) : in_width_ff;
      c_eff  = (in_channels_ff == 5'd0) ? 5'd1 :
               (32'(in_channels_ff) > MAX_IN_CHANNELS) ? 5'(MAX_IN_CHANNELS) : in_channels_ff;
      sr_eff = (stride_rows_ff == 4'd0) ? 4'd1 : stride_rows_ff;
      sc_eff = (stride_cols_ff == 4'd0) ? 4'd1 : stride_cols_ff;
      d_eff  = (dilation_ff == 4'd0) ? 4'd1 : dilation_ff;
   end

   // Output position check: row < floor(num/stride)+1  <=>  row*stride <= num
   always_comb begin
      row_mul  = 11'(req_row) * 11'(sr_eff);
      col_mul  = 11'(req_col) * 11'(sc_eff);
      num_rows = $signed(COORD_W'(h_eff)) + $signed(COORD_W'({pad_rows_ff, 1'b0}))
                 - $signed(COORD_W'(d_eff) * COORD_W'(TAP_ROWS - 1)) - COORD_W'(1);
      num_cols = $signed(COORD_W'(w_eff)) + $signed(COORD_W'({pad_cols_ff, 1'b0}))
                 - $signed(COORD_W'(d_eff) * COORD_W'(TAP_COLS - 1)) - COORD_W'(1);
      coord_ok = !num_rows[COORD_W-1] && !num_cols[COORD_W-1]
                 && ($signed(COORD_W'(row_mul)) <= num_rows)
                 && ($signed(COORD_W'(col_mul)) <= num_cols)
                 && (32'(req_out_channel) < MAX_OUT_CHANNELS);
      rbase    = $signed(COORD_W'(row_mul)) - $signed(COORD_W'(pad_rows_ff));
      cbase    = $signed(COORD_W'(col_mul)) - $signed(COORD_W'(pad_cols_ff));
   end

   always_comb begin
      c_last   = CH_AW'(c_eff - 5'd1);
      tap_last = (c_ff == c_last) && (32'(a_ff) == TAP_ROWS - 1)
                 && (32'(b_ff) == TAP_COLS - 1);
      tap_ok   = !ih_ff[COORD_W-1] && !iw_ff[COORD_W-1]
                 && (ih_ff < $signed(COORD_W'(h_eff)))
                 && (iw_ff < $signed(COORD_W'(w_eff)));
      feat_raddr = FEAT_AW'((FEAT_AW'(c_ff) * FEAT_AW'(MAX_HEIGHT)
                   + FEAT_AW'(ih_ff[ROW_AW-1:0])) * FEAT_AW'(MAX_WIDTH)
                   + FEAT_AW'(iw_ff[COL_AW-1:0]));
   end

   // Load decode
   always_comb begin
      load_sat   = sat16(req_value);
      feat_waddr = FEAT_AW'((FEAT_AW'(req_in_channel) * FEAT_AW'(MAX_HEIGHT)
                   + FEAT_AW'(req_row)) * FEAT_AW'(MAX_WIDTH) + FEAT_AW'(req_col));
      wgt_waddr  = WGT_AW'(((WGT_AW'(req_out_channel) * WGT_AW'(MAX_IN_CHANNELS)
                   + WGT_AW'(req_in_channel)) * WGT_AW'(TAP_ROWS)
                   + WGT_AW'(req_kernel_row)) * WGT_AW'(TAP_COLS) + WGT_AW'(req_kernel_col));
      feat_we    = accept && (cmd_type'(req_command) == CMD_LOAD_ACT)
                   && (32'(req_in_channel) < MAX_IN_CHANNELS)
                   && (32'(req_row) < MAX_HEIGHT) && (32'(req_col) < MAX_WIDTH);
      wgt_we     = accept && (cmd_type'(req_command) == CMD_LOAD_WGT)
                   && (32'(req_out_channel) < MAX_OUT_CHANNELS)
                   && (32'(req_in_channel) < MAX_IN_CHANNELS)
                   && (32'(req_kernel_row) < TAP_ROWS) && (32'(req_kernel_col) < TAP_COLS);
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      busy       = (state_ff != ST_IDLE);
      accept     = start && !busy;
      do_compute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd_type'(req_command) == CMD_COMPUTE) && coord_ok) begin
               do_compute = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (p2_valid_ff && p2_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         in_height_ff   <= 7'd1;
         in_width_ff    <= 7'd1;
         in_channels_ff <= 5'd1;
         stride_rows_ff <= 4'd1;
         stride_cols_ff <= 4'd1;
         pad_rows_ff    <= 3'd0;
         pad_cols_ff    <= 3'd0;
         dilation_ff    <= 4'd1;
         for (int i = 0; i < MAX_OUT_CHANNELS; i++) begin
            bias_ff[i] <= '0;
         end
         p1_valid_ff    <= 1'b0;
         p1_last_ff     <= 1'b0;
         p2_valid_ff    <= 1'b0;
         p2_last_ff     <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (reg_index_type'(csr_index))
               REG_IN_HEIGHT:   in_height_ff   <= csr_wr_data[6:0];
               REG_IN_WIDTH:    in_width_ff    <= csr_wr_data[6:0];
               REG_IN_CHANNELS: in_channels_ff <= csr_wr_data[4:0];
               REG_STRIDE_ROWS: stride_rows_ff <= csr_wr_data[3:0];
               REG_STRIDE_COLS: stride_cols_ff <= csr_wr_data[3:0];
               REG_PAD_ROWS:    pad_rows_ff    <= csr_wr_data[2:0];
               REG_PAD_COLS:    pad_cols_ff    <= csr_wr_data[2:0];
               REG_DILATION:    dilation_ff    <= csr_wr_data[3:0];
               default: ;
            endcase
         end
         if (accept && (cmd_type'(req_command) == CMD_LOAD_BIAS)
             && (32'(req_out_channel) < MAX_OUT_CHANNELS)) begin
            bias_ff[req_out_channel] <= req_value;
         end
         p1_valid_ff   <= (state_ff == ST_RUN);
         p1_last_ff    <= (state_ff == ST_RUN) && tap_last;
         p2_valid_ff   <= p1_valid_ff;
         p2_last_ff    <= p1_last_ff;
         // Strobe for a finished sum, or at once for an out-of-range coordinate
         rsp_strobe_ff <= (p2_valid_ff && p2_last_ff)
                          || (accept && (cmd_type'(req_command) == CMD_COMPUTE) && !coord_ok);
      end
   end

   // Tap walk: kernel column innermost, then kernel row, then input channel
   always_ff @(posedge clock) begin
      if (do_compute) begin
         c_ff     <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         rbase_ff <= rbase;
         cbase_ff <= cbase;
         ih_ff    <= rbase;
         iw_ff    <= cbase;
         waddr_ff <= WGT_AW'(WGT_AW'(req_out_channel) * WGT_AW'(TAPS_PER_OC));
      end else if (state_ff == ST_RUN) begin
         waddr_ff <= waddr_ff + WGT_AW'(1);
         if (32'(b_ff) == TAP_COLS - 1) begin
            b_ff  <= '0;
            iw_ff <= cbase_ff;
            if (32'(a_ff) == TAP_ROWS - 1) begin
               a_ff  <= '0;
               ih_ff <= rbase_ff;
               c_ff  <= c_ff + CH_AW'(1);
            end else begin
               a_ff  <= a_ff + KR_AW'(1);
               ih_ff <= ih_ff + $signed(COORD_W'(d_eff));
            end
         end else begin
            b_ff  <= b_ff + KC_AW'(1);
            iw_ff <= iw_ff + $signed(COORD_W'(d_eff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem_ff[feat_waddr] <= load_sat;
      end
      feat_rd_ff <= feat_mem_ff[feat_raddr];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem_ff[wgt_waddr] <= load_sat;
      end
      wgt_rd_ff <= wgt_mem_ff[waddr_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN) begin
         p1_ok_ff <= tap_ok;
      end
   end

   assign acc_sum = acc_ff + ACC_W'(product_ff);

   // Multiply, accumulate, saturate
   always_ff @(posedge clock) begin
      product_ff <= p1_ok_ff ? (feat_rd_ff * wgt_rd_ff) : 32'sd0;
      if (do_compute) begin
         acc_ff <= ACC_W'(bias_ff[req_out_channel]);
      end else if (p2_valid_ff) begin
         acc_ff <= acc_sum;
      end
      if (p2_valid_ff && p2_last_ff) begin
         if (acc_sum > 40'sh007FFFFFFF) begin
            rsp_value_ff  <= 32'sh7FFFFFFF;
            rsp_status_ff <= STS_SATURATED;
         end else if (acc_sum < -40'sh0080000000) begin
            rsp_value_ff  <= -32'sh80000000;
            rsp_status_ff <= STS_SATURATED;
         end else begin
            rsp_value_ff  <= acc_sum[31:0];
            rsp_status_ff <= STS_OK;
         end
      end else if (accept && (cmd_type'(req_command) == CMD_COMPUTE) && !coord_ok) begin
         rsp_value_ff  <= '0;
         rsp_status_ff <= STS_RANGE;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
